// ===== hdl/mop_pkg.sv =====
`timescale 1ns / 1ps
package mop_pkg;
	localparam int GRID_SIDE_DEF = 1024;
	localparam int WORD_BITS = 64;

	function automatic logic [31:0] spread(input logic [15:0] v);
		logic [31:0] r;
		r = '0;
		for (int b = 0; b < 16; b++) r[2*b] = v[b];
		return r;
	endfunction

	function automatic logic [15:0] gather(input logic [31:0] v);
		logic [15:0] r;
		for (int b = 0; b < 16; b++) r[b] = v[2*b];
		return r;
	endfunction
endpackage

// ===== hdl/morton_order_rect_packer.sv =====
`timescale 1ns / 1ps
// per item: the search visits morton indices in S_CAND, tests each bitmap word with a read
// (S_RD, S_CHK), marks each word with a read and a write (S_MRD, S_MWR), then strobes done
// from S_OUT; a zero-size item goes to S_ZERO; a new_batch item first runs the clearing pass
// throughput: one item at a time, busy high until done; results strobe one cycle, the receiver
// cannot stall
// reset: window 1x1, extents 0, x_in_low_bit 0, bitmap cleared by the pass after reset
module morton_order_rect_packer #(
	parameter int GRID_SIDE = mop_pkg::GRID_SIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic        new_batch,
	input  logic [10:0] rect_width,
	input  logic [10:0] rect_height,
	output logic        done,
	output logic        placed,
	output logic        no_room,
	output logic [9:0]  pos_x,
	output logic [9:0]  pos_y,
	output logic [10:0] win_width,
	output logic [10:0] win_height,
	output logic [19:0] extent_index
);
	import mop_pkg::*;

	localparam int SB = $clog2(GRID_SIDE);
	localparam int WPR = (GRID_SIDE + WORD_BITS - 1) / WORD_BITS;
	localparam int DEPTH = GRID_SIDE * WPR;
	localparam int AW = $clog2(DEPTH);

	typedef enum logic [8:0] {
		S_CLR   = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_CAND  = 9'b000000100,
		S_RD    = 9'b000001000,
		S_CHK   = 9'b000010000,
		S_MRD   = 9'b000100000,
		S_MWR   = 9'b001000000,
		S_OUT   = 9'b010000000,
		S_ZERO  = 9'b100000000
	} state_t;

	state_t st_q;
	logic xlow_q;
	logic srch_q;
	logic [AW-1:0] clr_q;
	logic [12:0] ww_q, wh_q;
	logic [SB-1:0] ex_q, ey_q;
	logic [11:0] rw_q, rh_q;
	logic [2*SB+1:0] ix_q;
	logic [SB:0] cx_q, cy_q;
	logic [SB:0] r_q;
	logic [SB+1:0] col_q;
	logic pl_q, nr_q;

	logic ram_we;
	logic [AW-1:0] ram_wa, ram_ra;
	logic [WORD_BITS-1:0] ram_wd, ram_rd;

	mop_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	logic [15:0] lo, hi;
	logic [SB:0] x_c, y_c;
	logic [SB+1:0] col_end, span_end;
	logic [SB:0] row;
	logic [AW-1:0] wa;
	logic [WORD_BITS-1:0] mask;
	logic [6:0] off, nbits;
	logic [11:0] remw;

	always_comb begin
		lo = gather(32'(ix_q));
		hi = gather(32'(ix_q >> 1));
		x_c = xlow_q ? lo[SB:0] : hi[SB:0];
		y_c = xlow_q ? hi[SB:0] : lo[SB:0];
		row = cy_q + r_q;
		off = 7'(col_q % WORD_BITS);
		remw = 12'(cx_q + rw_q - col_q);
		nbits = (remw > 12'(WORD_BITS - off)) ? 7'(WORD_BITS - off) : remw[6:0];
		mask = ((nbits == 7'(WORD_BITS)) ? '1 :
			((WORD_BITS'(1) << nbits) - WORD_BITS'(1))) << off;
		span_end = col_q + (SB+2)'(nbits);
		col_end = (SB+2)'(cx_q) + (SB+2)'(rw_q);
		wa = AW'(row[SB-1:0]) * AW'(WPR) + AW'(col_q / WORD_BITS);
	end

	always_comb begin
		ram_we = 1'b0;
		ram_wa = wa;
		ram_wd = ram_rd | mask;
		ram_ra = wa;
		if (st_q == S_CLR) begin
			ram_we = 1'b1;
			ram_wa = clr_q;
			ram_wd = '0;
		end else if (st_q == S_MWR) begin
			ram_we = 1'b1;
		end
	end

	assign busy = (st_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			xlow_q <= 1'b0;
			srch_q <= 1'b0;
			clr_q <= '0;
			ww_q <= 13'd1;
			wh_q <= 13'd1;
			ex_q <= '0;
			ey_q <= '0;
			rw_q <= '0;
			rh_q <= '0;
			ix_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			r_q <= '0;
			col_q <= '0;
			pl_q <= 1'b0;
			nr_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_we) xlow_q <= cfg_wdata;
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						clr_q <= '0;
						srch_q <= 1'b0;
						if (!srch_q)
							st_q <= S_IDLE;
						else
							st_q <= (rw_q != 0 && rh_q != 0) ? S_CAND : S_ZERO;
					end
				end
				S_IDLE: begin
					if (start) begin
						rw_q <= 12'(rect_width);
						rh_q <= 12'(rect_height);
						ix_q <= '0;
						pl_q <= 1'b0;
						nr_q <= 1'b0;
						if (new_batch) begin
							ww_q <= 13'd1;
							wh_q <= 13'd1;
							ex_q <= '0;
							ey_q <= '0;
							srch_q <= 1'b1;
							st_q <= S_CLR;
						end else if (rect_width == 0 || rect_height == 0)
							st_q <= S_ZERO;
						else
							st_q <= S_CAND;
					end
				end
				S_CAND: begin
					if (13'(x_c) >= ww_q && 13'(y_c) >= wh_q) begin
						ix_q <= '0;
						if (ww_q == wh_q && wh_q < 13'(GRID_SIDE))
							wh_q <= wh_q << 1;
						else if (ww_q < 13'(GRID_SIDE))
							ww_q <= ww_q << 1;
						else if (wh_q < 13'(GRID_SIDE))
							wh_q <= wh_q << 1;
						else begin
							nr_q <= 1'b1;
							st_q <= S_OUT;
						end
					end else if (13'(x_c) + 13'(rw_q) <= ww_q &&
							13'(y_c) + 13'(rh_q) <= wh_q) begin
						cx_q <= x_c;
						cy_q <= y_c;
						r_q <= '0;
						col_q <= (SB+2)'(x_c);
						st_q <= S_RD;
					end else
						ix_q <= ix_q + (2*SB+2)'(1);
				end
				S_RD: st_q <= S_CHK;
				S_CHK: begin
					if ((ram_rd & mask) != '0) begin
						ix_q <= ix_q + (2*SB+2)'(1);
						st_q <= S_CAND;
					end else if (span_end < col_end) begin
						col_q <= span_end;
						st_q <= S_RD;
					end else if (12'(r_q) + 12'd1 < rh_q) begin
						r_q <= r_q + (SB+1)'(1);
						col_q <= (SB+2)'(cx_q);
						st_q <= S_RD;
					end else begin
						r_q <= '0;
						col_q <= (SB+2)'(cx_q);
						st_q <= S_MRD;
					end
				end
				S_MRD: st_q <= S_MWR;
				S_MWR: begin
					if (span_end < col_end) begin
						col_q <= span_end;
						st_q <= S_MRD;
					end else if (12'(r_q) + 12'd1 < rh_q) begin
						r_q <= r_q + (SB+1)'(1);
						col_q <= (SB+2)'(cx_q);
						st_q <= S_MRD;
					end else begin
						pl_q <= 1'b1;
						if (SB'(col_end - 1) > ex_q) ex_q <= SB'(col_end - 1);
						if (SB'(12'(cy_q) + rh_q - 12'd1) > ey_q)
							ey_q <= SB'(12'(cy_q) + rh_q - 12'd1);
						st_q <= S_OUT;
					end
				end
				S_ZERO: begin
					done <= 1'b1;
					st_q <= S_IDLE;
				end
				S_OUT: begin
					done <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	logic [31:0] sx, sy;
	always_comb begin
		sx = spread(16'(ex_q));
		sy = spread(16'(ey_q));
		placed = pl_q;
		no_room = nr_q;
		pos_x = pl_q ? 10'(cx_q) : 10'd0;
		pos_y = pl_q ? 10'(cy_q) : 10'd0;
		win_width = 11'(ww_q);
		win_height = 11'(wh_q);
		extent_index = xlow_q ? 20'(sx | (sy << 1)) : 20'(sy | (sx << 1));
	end
endmodule

// ===== hdl/mop_ram.sv =====
`timescale 1ns / 1ps
module mop_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
